// ===== hw/rtl/ssbc_pkg.sv =====
// Shared types and codes for the soft-switch bank controller.
package ssbc_pkg;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [3:0] PAGE_KBD    = 4'h0;
  localparam logic [3:0] PAGE_STATUS = 4'h1;
  localparam logic [3:0] PAGE_SPKR   = 4'h3;
  localparam logic [3:0] PAGE_VIDEO  = 4'h5;
  localparam logic [3:0] PAGE_BUTTON = 4'h6;
  localparam logic [3:0] PAGE_LC     = 4'h8;

  localparam logic [3:0] ST_KBD     = 4'h0;
  localparam logic [3:0] ST_BANK2   = 4'h1;
  localparam logic [3:0] ST_LCRAM   = 4'h2;
  localparam logic [3:0] ST_AUXRD   = 4'h3;
  localparam logic [3:0] ST_AUXWR   = 4'h4;
  localparam logic [3:0] ST_INTCX   = 4'h5;
  localparam logic [3:0] ST_ALTZP   = 4'h6;
  localparam logic [3:0] ST_SLOTC3  = 4'h7;
  localparam logic [3:0] ST_STORE80 = 4'h8;
  localparam logic [3:0] ST_VBL     = 4'h9;
  localparam logic [3:0] ST_TEXT    = 4'hA;
  localparam logic [3:0] ST_MIXED   = 4'hB;
  localparam logic [3:0] ST_PAGE2   = 4'hC;
  localparam logic [3:0] ST_HIRES   = 4'hD;
  localparam logic [3:0] ST_ALTCHR  = 4'hE;
  localparam logic [3:0] ST_COL80   = 4'hF;

  // memory switch bit positions
  localparam logic [2:0] MS_AUXRD   = 3'd0;
  localparam logic [2:0] MS_AUXWR   = 3'd1;
  localparam logic [2:0] MS_INTCX   = 3'd2;
  localparam logic [2:0] MS_ALTZP   = 3'd3;
  localparam logic [2:0] MS_SLOTC3  = 3'd4;
  localparam logic [2:0] MS_STORE80 = 3'd5;

  // video switch bit positions
  localparam logic [2:0] VS_TEXT   = 3'd0;
  localparam logic [2:0] VS_MIXED  = 3'd1;
  localparam logic [2:0] VS_PAGE2  = 3'd2;
  localparam logic [2:0] VS_HIRES  = 3'd3;
  localparam logic [2:0] VS_COL80  = 3'd4;
  localparam logic [2:0] VS_ALTCHR = 3'd5;

  localparam logic [7:0] FLAG_ON  = 8'h80;
  localparam logic [7:0] FLAG_OFF = 8'h00;

  localparam logic [1:0] LC_OFF   = 2'd0;
  localparam logic [1:0] LC_BANK2 = 2'd1;
  localparam logic [1:0] LC_BANK1 = 2'd2;

  typedef struct packed {
    logic [3:0] button_bits;
    logic [7:0] vblank_byte;
    logic [7:0] keyboard_byte;
    logic [7:0] switch_offset;
    logic       operation;
  } access_t;

  typedef struct packed {
    logic       speaker;
    logic       lc_write_bank_one;
    logic       lc_write_on;
    logic       lc_bank_two;
    logic       lc_ram_read;
    logic [3:0] annunciators;
    logic [5:0] video;
    logic [5:0] memory;
  } state_t;

  typedef struct packed {
    logic       speaker_level;
    logic [3:0] annunciators;
    logic [6:0] display_flags;
    logic [1:0] lc_write_select;
    logic [1:0] lc_read_select;
    logic       internal_slot_rom;
    logic       aux_zero_page;
    logic       aux_write;
    logic       aux_read;
    logic [7:0] read_data;
  } result_t;

  function automatic logic [2:0] c00x_bit(input logic [2:0] pair);
    logic [2:0] idx;
    case (pair)
      3'd0:    idx = MS_STORE80;
      3'd1:    idx = MS_AUXRD;
      3'd2:    idx = MS_AUXWR;
      3'd3:    idx = MS_INTCX;
      3'd4:    idx = MS_ALTZP;
      3'd5:    idx = MS_SLOTC3;
      3'd6:    idx = VS_COL80;
      default: idx = VS_ALTCHR;
    endcase
    return idx;
  endfunction

  function automatic logic [7:0] flag_byte(input logic on);
    return on ? FLAG_ON : FLAG_OFF;
  endfunction

endpackage

// ===== hw/rtl/ssbc_decode.sv =====
// Access decode: next switch state and result fields for one I/O page access.
module ssbc_decode (
  input  ssbc_pkg::access_t acc,
  input  ssbc_pkg::state_t  st,
  output ssbc_pkg::state_t  st_next,
  output ssbc_pkg::result_t res
);
  import ssbc_pkg::*;

  logic       is_write;
  logic [3:0] page;
  logic [3:0] low;
  logic [7:0] rdata;

  assign is_write = (acc.operation == OP_WRITE);
  assign page     = acc.switch_offset[7:4];
  assign low      = acc.switch_offset[3:0];

  always_comb begin
    st_next = st;
    rdata   = FLAG_OFF;
    case (page)
      PAGE_KBD: begin
        if (is_write) begin
          if (low[3:2] != 2'b11) begin
            st_next.memory[c00x_bit(low[3:1])] = low[0];
          end else begin
            st_next.video[c00x_bit(low[3:1])] = low[0];
          end
        end else begin
          rdata = acc.keyboard_byte;
        end
      end
      PAGE_STATUS: begin
        if (!is_write) begin
          case (low)
            ST_KBD:     rdata = acc.keyboard_byte;
            ST_BANK2:   rdata = flag_byte(st.lc_bank_two);
            ST_LCRAM:   rdata = flag_byte(st.lc_ram_read);
            ST_AUXRD:   rdata = flag_byte(st.memory[MS_AUXRD]);
            ST_AUXWR:   rdata = flag_byte(st.memory[MS_AUXWR]);
            ST_INTCX:   rdata = flag_byte(st.memory[MS_INTCX]);
            ST_ALTZP:   rdata = flag_byte(st.memory[MS_ALTZP]);
            ST_SLOTC3:  rdata = flag_byte(st.memory[MS_SLOTC3]);
            ST_STORE80: rdata = flag_byte(st.memory[MS_STORE80]);
            ST_VBL:     rdata = acc.vblank_byte;
            ST_TEXT:    rdata = flag_byte(st.video[VS_TEXT]);
            ST_MIXED:   rdata = flag_byte(st.video[VS_MIXED]);
            ST_PAGE2:   rdata = flag_byte(st.video[VS_PAGE2]);
            ST_HIRES:   rdata = flag_byte(st.video[VS_HIRES]);
            ST_ALTCHR:  rdata = flag_byte(st.video[VS_ALTCHR]);
            default:    rdata = flag_byte(st.video[VS_COL80]);
          endcase
        end
      end
      PAGE_SPKR: begin
        st_next.speaker = ~st.speaker;
      end
      PAGE_VIDEO: begin
        // annunciators use reversed sense: even offset sets
        if (!low[3]) begin
          st_next.video[{1'b0, low[2:1]}] = low[0];
        end else begin
          st_next.annunciators[low[2:1]] = ~low[0];
        end
      end
      PAGE_BUTTON: begin
        if (!is_write && (low inside {[4'd1:4'd3]})) begin
          rdata = flag_byte(acc.button_bits[low[1:0]]);
        end
      end
      PAGE_LC: begin
        st_next.lc_write_on       = low[0];
        st_next.lc_write_bank_one = low[3];
        st_next.lc_bank_two       = ~low[3];
        st_next.lc_ram_read       = (low[1] == low[0]);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.read_data         = rdata;
    res.aux_read          = st_next.memory[MS_AUXRD];
    res.aux_write         = st_next.memory[MS_AUXWR];
    res.aux_zero_page     = st_next.memory[MS_ALTZP];
    res.internal_slot_rom = st_next.memory[MS_INTCX];
    res.lc_read_select    = !st_next.lc_ram_read ? LC_OFF :
                            (st_next.lc_bank_two ? LC_BANK2 : LC_BANK1);
    res.lc_write_select   = !st_next.lc_write_on ? LC_OFF :
                            (st_next.lc_write_bank_one ? LC_BANK1 : LC_BANK2);
    res.display_flags     = {st_next.memory[MS_STORE80], st_next.video};
    res.annunciators      = st_next.annunciators;
    res.speaker_level     = st_next.speaker;
  end

endmodule

// ===== hw/rtl/soft_switch_bank_controller.sv =====
// Soft-switch and language-card bank controller, top level with stage registers.
//
// Usage:
//   Slave channel s_*: one I/O page access per transfer. s_tuser carries the
//   operation (0 read, 1 write); s_tdata carries offset, keyboard byte,
//   vertical blank byte and button levels.
//   Master channel m_*: one result per access, the read byte followed by the
//   memory-map selectors, display flags, annunciators and speaker level as
//   they stand after the access.
//   Path: an accepted access is held in the input register; its result is
//   then registered from the decode and presented on m_*.
//   Throughput: one access per cycle while m_tready stays high; the switch
//   state is updated by the single decode stage between the two registers.
//   Reset (rst, synchronous): all switches, annunciators, language-card
//   bank state and the speaker level go to zero; both stages empty.
//   Stall: while m_tready is low the result holds; one more access waits in
//   the input register and s_tready drops until the result is taken.
module soft_switch_bank_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] switch_offset, [15:8] keyboard_byte, [23:16] vblank_byte,
  // [27:24] button_bits, [31:28] zero
  input  logic [31:0] s_tdata,
  // [0] operation
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] read_data, [8] aux_read, [9] aux_write, [10] aux_zero_page,
  // [11] internal_slot_rom, [13:12] lc_read_select, [15:14] lc_write_select,
  // [22:16] display_flags, [26:23] annunciators, [27] speaker_level,
  // [31:28] zero
  output logic [31:0] m_tdata
);
  import ssbc_pkg::*;

  logic    in_valid;
  access_t in_acc;
  state_t  state;
  state_t  state_next;
  result_t res_next;
  result_t res;
  logic    out_free;
  logic    in_adv;

  assign out_free = !m_tvalid || m_tready;
  assign in_adv   = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  ssbc_decode u_decode (
    .acc     (in_acc),
    .st      (state),
    .st_next (state_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
      state    <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (in_adv) begin
        in_valid <= 1'b0;
      end
      if (in_adv) begin
        m_tvalid <= 1'b1;
        state    <= state_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_acc <= {s_tdata[27:0], s_tuser};
    end
    if (in_adv) begin
      res <= res_next;
    end
  end

  assign m_tdata = {4'b0000, res};

`ifndef ASSERT_OFF
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !in_adv |=> $stable(state))
    else $error("switch state changed without an access advancing");

  a_speaker_toggle: assert property (@(posedge clk) disable iff (rst)
    (in_adv && in_acc.switch_offset[7:4] == PAGE_SPKR) |=>
      state.speaker != $past(state.speaker))
    else $error("speaker page access did not toggle the level");

  a_lc_select: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.lc_read_select != 2'b11 && res.lc_write_select != 2'b11))
    else $error("invalid language-card select code");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!in_valid || !m_tvalid) |-> s_tready)
    else $error("input stalled with room in the pipeline");
`endif

endmodule
